FILE: src/sle_pkg.sv
package sle_pkg;

	localparam int DEPTH = 64;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int WORD_W = 32;
	localparam int POS_W = 7;
	localparam int OUT_W = 7;
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int GRP = 8;
	localparam int GRP_W = 3;
	localparam int NGRP = (DEPTH + GRP - 1) / GRP;

	localparam logic [OUT_W-1:0] NO_INDEX = '1;

	typedef enum logic [2:0] {
		ACT_PUSH_BACK  = 3'd0,
		ACT_PUSH_FRONT = 3'd1,
		ACT_POP_BACK   = 3'd2,
		ACT_POP_FRONT  = 3'd3,
		ACT_INSERT     = 3'd4,
		ACT_ERASE      = 3'd5,
		ACT_FIND       = 3'd6
	} action_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_BADPOS = 2'd3
	} status_t;

	typedef struct packed {
		logic                     shift_up;
		logic                     shift_down;
		logic [IDX_W-1:0]         pos;
		logic signed [WORD_W-1:0] value;
	} cell_cmd_t;

	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] idx;
	} find_res_t;

endpackage

FILE: src/sequential_list_engine.sv
// Ordered list of up to DEPTH signed 32-bit words held in a row of cells.
// Request channel: req_valid/req_ready with action, position and value.
// Result channel: res_valid/res_ready with status, found_index, entry_count.
// Every request gives exactly one result, in request order.
// The cells shift up for an insert, shift down for an erase and compare all
// entries against the value for a find, all in the cycle the request is taken.
// A result first waits in the match register, loaded at the accepting edge,
// and then moves to the output register through the first-match encoder
// once the output stage is free to advance.
// One request per cycle is accepted while results are being taken.
// When the receiver stalls, one result waits in the output register and one
// more in the match stage; req_ready then drops until the output moves.
// Reset clears the entry count and both stages; the words in the cells are
// not cleared, since an entry is only read after it has been written.
// A failed request (full, empty or bad position) leaves the list unchanged.
module sequential_list_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  logic [2:0]          action,
	input  logic [6:0]          position,
	input  logic signed [31:0]  value,
	output logic                res_valid,
	input  logic                res_ready,
	output logic [1:0]          status,
	output logic signed [6:0]   found_index,
	output logic [6:0]          entry_count
);

	localparam int D = sle_pkg::DEPTH;

	logic [sle_pkg::CNT_W-1:0]   cnt_q;
	logic [sle_pkg::CNT_W-1:0]   cnt_next;
	sle_pkg::status_t            st_next;
	logic                        find_next;
	sle_pkg::cell_cmd_t          cmd;
	logic                        req_acc;
	logic                        adv_ok;
	logic [sle_pkg::CMP_W-1:0]   pos_ext;
	logic [sle_pkg::CMP_W-1:0]   cnt_ext;
	logic                        full;
	logic                        empty;

	logic signed [sle_pkg::WORD_W-1:0] words [D];
	logic [D-1:0]                      match;

	logic                        v_s1;
	logic [D-1:0]                match_s1;
	sle_pkg::status_t            status_s1;
	logic [sle_pkg::CNT_W-1:0]   count_s1;
	logic                        find_s1;

	sle_pkg::find_res_t          fres;

	logic                        res_valid_q;
	sle_pkg::status_t            status_q;
	logic [6:0]                  found_q;
	logic [6:0]                  count_out_q;

	assign adv_ok    = !res_valid_q || res_ready;
	assign req_ready = !v_s1 || adv_ok;
	assign req_acc   = req_valid && req_ready;

	assign pos_ext = sle_pkg::CMP_W'(position);
	assign cnt_ext = sle_pkg::CMP_W'(cnt_q);
	assign full    = (cnt_q == sle_pkg::CNT_W'(D));
	assign empty   = (cnt_q == '0);

	always_comb begin
		cmd.shift_up   = 1'b0;
		cmd.shift_down = 1'b0;
		cmd.pos        = '0;
		cmd.value      = value;
		st_next        = sle_pkg::ST_OK;
		cnt_next       = cnt_q;
		find_next      = 1'b0;
		case (sle_pkg::action_t'(action))
			sle_pkg::ACT_PUSH_BACK: begin
				if (full) begin
					st_next = sle_pkg::ST_FULL;
				end else begin
					cmd.shift_up = 1'b1;
					cmd.pos      = sle_pkg::IDX_W'(cnt_q);
					cnt_next     = cnt_q + 1'b1;
				end
			end
			sle_pkg::ACT_PUSH_FRONT: begin
				if (full) begin
					st_next = sle_pkg::ST_FULL;
				end else begin
					cmd.shift_up = 1'b1;
					cnt_next     = cnt_q + 1'b1;
				end
			end
			sle_pkg::ACT_POP_BACK: begin
				if (empty) begin
					st_next = sle_pkg::ST_EMPTY;
				end else begin
					cnt_next = cnt_q - 1'b1;
				end
			end
			sle_pkg::ACT_POP_FRONT: begin
				if (empty) begin
					st_next = sle_pkg::ST_EMPTY;
				end else begin
					cmd.shift_down = 1'b1;
					cnt_next       = cnt_q - 1'b1;
				end
			end
			sle_pkg::ACT_INSERT: begin
				if (full) begin
					st_next = sle_pkg::ST_FULL;
				end else if (pos_ext > cnt_ext) begin
					st_next = sle_pkg::ST_BADPOS;
				end else begin
					cmd.shift_up = 1'b1;
					cmd.pos      = sle_pkg::IDX_W'(position);
					cnt_next     = cnt_q + 1'b1;
				end
			end
			sle_pkg::ACT_ERASE: begin
				if (empty) begin
					st_next = sle_pkg::ST_EMPTY;
				end else if (pos_ext >= cnt_ext) begin
					st_next = sle_pkg::ST_BADPOS;
				end else begin
					cmd.shift_down = 1'b1;
					cmd.pos        = sle_pkg::IDX_W'(position);
					cnt_next       = cnt_q - 1'b1;
				end
			end
			sle_pkg::ACT_FIND: begin
				find_next = 1'b1;
			end
			default: begin
			end
		endcase
		// The cells move only for an accepted request.
		if (!req_acc) begin
			cmd.shift_up   = 1'b0;
			cmd.shift_down = 1'b0;
		end
	end

	for (genvar g = 0; g < D; g++) begin : g_cell
		logic signed [sle_pkg::WORD_W-1:0] left_w;
		logic signed [sle_pkg::WORD_W-1:0] right_w;
		if (g == 0) begin : g_lo
			assign left_w = words[0];
		end else begin : g_lo
			assign left_w = words[g-1];
		end
		if (g == D - 1) begin : g_hi
			assign right_w = words[D-1];
		end else begin : g_hi
			assign right_w = words[g+1];
		end
		sle_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.idx        (sle_pkg::IDX_W'(g)),
			.count      (cnt_q),
			.left_word  (left_w),
			.right_word (right_w),
			.word       (words[g]),
			.match      (match[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			v_s1  <= 1'b0;
		end else begin
			if (req_acc) begin
				cnt_q <= cnt_next;
				v_s1  <= 1'b1;
			end else if (adv_ok) begin
				v_s1 <= 1'b0;
			end
		end
	end

	// The match vector sees the list as it was before this request.
	always_ff @(posedge clk) begin
		if (req_acc) begin
			match_s1  <= match;
			status_s1 <= st_next;
			count_s1  <= cnt_next;
			find_s1   <= find_next;
		end
	end

	sle_find u_find (
		.match (match_s1),
		.res   (fres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			if (v_s1 && adv_ok) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && adv_ok) begin
			status_q    <= status_s1;
			found_q     <= (find_s1 && fres.hit) ? 7'(fres.idx) : sle_pkg::NO_INDEX;
			count_out_q <= 7'(count_s1);
		end
	end

	assign res_valid   = res_valid_q;
	assign status      = status_q;
	assign found_index = found_q;
	assign entry_count = count_out_q;

`ifndef NO_ASSERTIONS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= sle_pkg::CNT_W'(D))
		else $error("entry count above capacity");

	a_shift_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.shift_up && cmd.shift_down))
		else $error("cells told to shift both ways");

	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift_up |=> cnt_q == sle_pkg::CNT_W'($past(cnt_q) + 1'b1))
		else $error("insert did not grow the count");

	a_del_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift_down |=> cnt_q == sle_pkg::CNT_W'($past(cnt_q) - 1'b1))
		else $error("erase did not shrink the count");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (found_index != sle_pkg::NO_INDEX) |-> status == sle_pkg::ST_OK)
		else $error("found index reported with error status");
`endif

endmodule

FILE: src/sle_cell.sv
module sle_cell (
	input  logic                              clk,
	input  sle_pkg::cell_cmd_t                cmd,
	input  logic [sle_pkg::IDX_W-1:0]         idx,
	input  logic [sle_pkg::CNT_W-1:0]         count,
	input  logic signed [sle_pkg::WORD_W-1:0] left_word,
	input  logic signed [sle_pkg::WORD_W-1:0] right_word,
	output logic signed [sle_pkg::WORD_W-1:0] word,
	output logic                              match
);

	logic signed [sle_pkg::WORD_W-1:0] word_q;

	// Insert: the target cell takes the new word and every cell above it takes
	// its lower neighbor. Erase: the target and every cell above take the upper one.
	always_ff @(posedge clk) begin
		if (cmd.shift_up) begin
			if (idx == cmd.pos) begin
				word_q <= cmd.value;
			end else if (idx > cmd.pos) begin
				word_q <= left_word;
			end
		end else if (cmd.shift_down) begin
			if (idx >= cmd.pos) begin
				word_q <= right_word;
			end
		end
	end

	assign word  = word_q;
	assign match = (sle_pkg::CNT_W'(idx) < count) && (word_q == cmd.value);

endmodule

FILE: src/sle_find.sv
module sle_find (
	input  logic [sle_pkg::DEPTH-1:0] match,
	output sle_pkg::find_res_t        res
);

	logic [sle_pkg::NGRP*sle_pkg::GRP-1:0] padded;
	logic [sle_pkg::NGRP-1:0]              grp_any;
	logic [sle_pkg::GRP_W-1:0]             grp_off [sle_pkg::NGRP];

	assign padded = (sle_pkg::NGRP*sle_pkg::GRP)'(match);

	// First hit inside each group of eight.
	always_comb begin
		for (int g = 0; g < sle_pkg::NGRP; g++) begin
			grp_any[g] = |padded[g*sle_pkg::GRP +: sle_pkg::GRP];
			grp_off[g] = '0;
			for (int k = sle_pkg::GRP - 1; k >= 0; k--) begin
				if (padded[g*sle_pkg::GRP + k]) begin
					grp_off[g] = sle_pkg::GRP_W'(k);
				end
			end
		end
	end

	// Lowest group with a hit wins.
	always_comb begin
		res.hit = 1'b0;
		res.idx = '0;
		for (int g = sle_pkg::NGRP - 1; g >= 0; g--) begin
			if (grp_any[g]) begin
				res.hit = 1'b1;
				res.idx = sle_pkg::IDX_W'(g * sle_pkg::GRP) + sle_pkg::IDX_W'(grp_off[g]);
			end
		end
	end

endmodule

FILE: verif/sequential_list_engine_test.sv
`timescale 1ns / 100ps

module sequential_list_engine_test;

	localparam logic [2:0] ACT_UNUSED = 3'd7;
	localparam int RANDOM_ITEMS = 900;
	localparam int CYCLE_LIMIT = 300000;
	localparam int DRAIN_CYCLES = 8;

	typedef enum int {MIX_GROW, MIX_SHRINK, MIX_EVEN} traffic_mix_t;
	typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_pattern_t;

	typedef struct {
		sle_pkg::status_t status;
		logic [6:0]       found_index;
		logic [6:0]       entry_count;
	} list_outcome_t;

	class list_mirror;
		logic signed [31:0] words [sle_pkg::DEPTH];
		int held;
		int errors;
		list_outcome_t awaited [$];

		function new();
			held = 0;
			errors = 0;
		endfunction

		function sle_pkg::status_t add_word(int pos, logic signed [31:0] word);
			if (held >= sle_pkg::DEPTH)
				return sle_pkg::ST_FULL;
			if (pos > held)
				return sle_pkg::ST_BADPOS;
			for (int i = held; i > pos; i--)
				words[i] = words[i - 1];
			words[pos] = word;
			held++;
			return sle_pkg::ST_OK;
		endfunction

		function sle_pkg::status_t drop_word(int pos);
			if (held == 0)
				return sle_pkg::ST_EMPTY;
			if (pos >= held)
				return sle_pkg::ST_BADPOS;
			for (int i = pos; i + 1 < held; i++)
				words[i] = words[i + 1];
			held--;
			return sle_pkg::ST_OK;
		endfunction

		function void note_request(logic [2:0] act, logic [6:0] pos, logic signed [31:0] val);
			list_outcome_t outcome;
			bit hit;
			outcome.status = sle_pkg::ST_OK;
			outcome.found_index = sle_pkg::NO_INDEX;
			hit = 1'b0;
			case (act)
				sle_pkg::ACT_PUSH_BACK:  outcome.status = add_word(held, val);
				sle_pkg::ACT_PUSH_FRONT: outcome.status = add_word(0, val);
				sle_pkg::ACT_POP_BACK: begin
					if (held == 0)
						outcome.status = sle_pkg::ST_EMPTY;
					else
						held--;
				end
				sle_pkg::ACT_POP_FRONT:  outcome.status = drop_word(0);
				sle_pkg::ACT_INSERT:     outcome.status = add_word(int'(pos), val);
				sle_pkg::ACT_ERASE:      outcome.status = drop_word(int'(pos));
				sle_pkg::ACT_FIND: begin
					for (int i = 0; i < held; i++) begin
						if (!hit && words[i] == val) begin
							outcome.found_index = 7'(i);
							hit = 1'b1;
						end
					end
				end
				default: ;
			endcase
			outcome.entry_count = 7'(held);
			awaited.push_back(outcome);
		endfunction

		function void check_result(logic [1:0] st, logic [6:0] fi, logic [6:0] cnt);
			list_outcome_t want;
			if (awaited.size() == 0) begin
				$error("result with no request pending: status %0d, found_index %0d, entry_count %0d",
					st, $signed(fi), cnt);
				errors++;
				return;
			end
			want = awaited.pop_front();
			if (st !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, st);
				errors++;
			end
			if (fi !== want.found_index) begin
				$error("found_index: expected %0d, got %0d", $signed(want.found_index), $signed(fi));
				errors++;
			end
			if (cnt !== want.entry_count) begin
				$error("entry_count: expected %0d, got %0d", want.entry_count, cnt);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	logic [2:0] action = sle_pkg::ACT_PUSH_BACK;
	logic [6:0] position = '0;
	logic signed [31:0] value = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	logic [1:0] status;
	logic signed [6:0] found_index;
	logic [6:0] entry_count;

	list_mirror mirror = new();

	rx_pattern_t rx_mode = RX_OPEN;
	int rx_left = 100;

	sequential_list_engine uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.action(action),
		.position(position),
		.value(value),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.status(status),
		.found_index(found_index),
		.entry_count(entry_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("sequential_list_engine test failed");
		$finish;
	end

	// Result side: check what was taken at this edge, then pick the next ready.
	always @(posedge clk) begin
		if (res_valid && res_ready)
			mirror.check_result(status, found_index, entry_count);
		if (rx_left == 0) begin
			rx_mode <= rx_pattern_t'($urandom_range(0, 3));
			rx_left <= $urandom_range(32, 256);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			RX_OPEN:     res_ready <= 1'b1;
			RX_LIGHT:    res_ready <= ($urandom_range(0, 3) != 0);
			RX_HEAVY:    res_ready <= ($urandom_range(0, 5) == 0);
			RX_PERIODIC: res_ready <= ((rx_left % 16) < 5);
			default:     res_ready <= 1'b1;
		endcase
	end

	// Called at a rising edge; returns at the edge where the request is taken.
	task automatic send_request(input logic [2:0] a, input logic [6:0] p,
			input logic signed [31:0] v);
		req_valid <= 1'b1;
		action <= a;
		position <= p;
		value <= v;
		do @(posedge clk); while (!req_ready);
		mirror.note_request(a, p, v);
	endtask

	function automatic logic signed [31:0] pick_word();
		if ($urandom_range(0, 3) != 0)
			return $urandom;
		case ($urandom_range(0, 4))
			0:       return 32'sh7FFFFFFF;
			1:       return 32'sh80000000;
			2:       return 32'sh0;
			3:       return -32'sd1;
			default: return $urandom_range(0, 7);
		endcase
	endfunction

	task automatic pick_request(input traffic_mix_t mix, output logic [2:0] a,
			output logic [6:0] p, output logic signed [31:0] v);
		sle_pkg::action_t kinds [7];
		int weights [7];
		int total;
		int roll;
		int held;
		kinds = '{sle_pkg::ACT_PUSH_BACK, sle_pkg::ACT_PUSH_FRONT, sle_pkg::ACT_POP_BACK,
			sle_pkg::ACT_POP_FRONT, sle_pkg::ACT_INSERT, sle_pkg::ACT_ERASE,
			sle_pkg::ACT_FIND};
		case (mix)
			MIX_GROW:   weights = '{30, 20, 4, 3, 30, 3, 8};
			MIX_SHRINK: weights = '{5, 5, 25, 20, 5, 27, 11};
			default:    weights = '{14, 14, 14, 14, 14, 14, 14};
		endcase
		held = mirror.held;
		total = 0;
		foreach (weights[k])
			total += weights[k];
		// A small share of requests carry the unused action code.
		roll = $urandom_range(0, total + 1);
		a = ACT_UNUSED;
		foreach (weights[k]) begin
			if (a == ACT_UNUSED && roll < weights[k])
				a = kinds[k];
			roll -= weights[k];
		end
		case (a)
			sle_pkg::ACT_INSERT: begin
				if ($urandom_range(0, 9) < 8)
					p = 7'($urandom_range(0, held));
				else
					p = 7'($urandom_range(0, 127));
			end
			sle_pkg::ACT_ERASE: begin
				if (held > 0 && $urandom_range(0, 9) < 8)
					p = 7'($urandom_range(0, held - 1));
				else
					p = 7'($urandom_range(0, 127));
			end
			default: p = 7'($urandom_range(0, 127));
		endcase
		if (a == sle_pkg::ACT_FIND && held > 0 && $urandom_range(0, 9) < 6)
			v = mirror.words[$urandom_range(0, held - 1)];
		else
			v = pick_word();
	endtask

	initial begin
		int burst;
		int gap;
		int counted;
		int seg_left;
		traffic_mix_t mix;
		logic [2:0] a;
		logic [6:0] p;
		logic signed [31:0] v;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty list corner cases first, then a short list with duplicates.
		send_request(sle_pkg::ACT_POP_BACK, 7'd0, 32'sd0);
		send_request(sle_pkg::ACT_POP_FRONT, 7'd127, 32'sd0);
		send_request(sle_pkg::ACT_ERASE, 7'd0, 32'sd0);
		send_request(sle_pkg::ACT_FIND, 7'd0, 32'sd0);
		send_request(sle_pkg::ACT_INSERT, 7'd1, 32'sd5);
		send_request(sle_pkg::ACT_PUSH_FRONT, 7'd0, 32'sh7FFFFFFF);
		send_request(sle_pkg::ACT_PUSH_BACK, 7'd127, 32'sh80000000);
		send_request(sle_pkg::ACT_INSERT, 7'd2, 32'sd0);
		send_request(sle_pkg::ACT_INSERT, 7'd0, -32'sd1);
		send_request(sle_pkg::ACT_INSERT, 7'd127, 32'sd9);
		send_request(sle_pkg::ACT_ERASE, 7'd4, 32'sd0);
		send_request(sle_pkg::ACT_ERASE, 7'd127, 32'sd0);
		send_request(sle_pkg::ACT_PUSH_BACK, 7'd0, 32'sh7FFFFFFF);
		send_request(sle_pkg::ACT_FIND, 7'd0, 32'sh7FFFFFFF);
		send_request(sle_pkg::ACT_FIND, 7'd0, 32'sd12345);
		send_request(ACT_UNUSED, 7'd127, -32'sd1);
		send_request(sle_pkg::ACT_ERASE, 7'd2, 32'sd0);
		send_request(sle_pkg::ACT_POP_BACK, 7'd0, 32'sd0);
		send_request(sle_pkg::ACT_POP_FRONT, 7'd0, 32'sd0);
		send_request(sle_pkg::ACT_FIND, 7'd0, 32'sd0);
		send_request(ACT_UNUSED, 7'd0, 32'sd0);
		send_request(sle_pkg::ACT_POP_BACK, 7'd0, 32'sd0);
		send_request(sle_pkg::ACT_POP_BACK, 7'd0, 32'sd0);
		send_request(sle_pkg::ACT_FIND, 7'd0, 32'sh7FFFFFFF);

		// Segments pick a filling, draining or even mix at random so the list hits
		// both full and empty many times.
		counted = 0;
		mix = MIX_GROW;
		seg_left = 100;
		while (counted < RANDOM_ITEMS) begin
			if ($urandom_range(0, 7) == 0)
				burst = $urandom_range(50, 150);
			else
				burst = $urandom_range(1, 20);
			repeat (burst) begin
				if (seg_left == 0) begin
					mix = traffic_mix_t'($urandom_range(0, 2));
					seg_left = $urandom_range(60, 160);
				end
				seg_left--;
				pick_request(mix, a, p, v);
				send_request(a, p, v);
				if (a != ACT_UNUSED)
					counted++;
			end
			gap = $urandom_range(0, 12);
			if (gap != 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		req_valid <= 1'b0;

		while (mirror.awaited.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mirror.errors == 0)
			$display("sequential_list_engine test passed");
		else
			$display("sequential_list_engine test failed");
		$finish;
	end

endmodule

FILE: sequential_list_engine.f
src/sle_pkg.sv
src/sle_cell.sv
src/sle_find.sv
src/sequential_list_engine.sv
verif/sequential_list_engine_test.sv
